[design/mbw_pkg.sv]
// ---------------------------------------------------------------------------
// mbw_pkg
// Shared types, constants and the header byte lookup for the 1-bit BMP
// stream writer.
// ---------------------------------------------------------------------------
package mbw_pkg;

    localparam int unsigned MAX_WIDTH_DEF   = 65535;
    localparam int unsigned QUEUE_DEPTH_DEF = 4;

    localparam int unsigned HDR_BYTES = 62;
    localparam int unsigned INFO_SIZE = 40;
    localparam logic [31:0] WHITE_RGB = 32'h00FF_FFFF;
    localparam int unsigned HDR_POS_W = 6;

    // pixels per meter = dpi * 5000 / 127, split as dpi*whole + dpi*frac/127
    localparam int unsigned DPM_NUM     = 5000;
    localparam int unsigned DPM_DEN     = 127;
    localparam int unsigned DPM_WHOLE   = DPM_NUM / DPM_DEN;
    localparam int unsigned DPM_FRAC    = DPM_NUM % DPM_DEN;
    localparam int unsigned DPM_W       = 22;
    localparam int unsigned RECIP_SHIFT = 22;
    localparam int unsigned RECIP       = (1 << RECIP_SHIFT) / DPM_DEN;
    localparam int unsigned PROD_W      = DPM_W + 16;

    localparam int unsigned CFG_IDX_W  = 2;
    localparam int unsigned CFG_DATA_W = 16;
    localparam logic [CFG_IDX_W-1:0] CFG_IMAGE_WIDTH    = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_IMAGE_HEIGHT   = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_RESOLUTION_DPI = 2'd2;

    localparam logic [15:0] RST_WIDTH  = 16'd1;
    localparam logic [15:0] RST_HEIGHT = 16'd1;
    localparam logic [15:0] RST_DPI    = 16'd300;

    localparam logic CMD_HEADER = 1'b0;

    typedef enum logic {
        DESC_HEADER,
        DESC_DATA
    } t_kind;

    // one queued job for the back end
    typedef struct packed {
        t_kind       kind;
        logic [7:0]  data;
        logic [1:0]  pad;
    } t_desc;

    typedef struct packed {
        logic [15:0] width;
        logic [15:0] height;
        logic [31:0] file_size;
        logic [31:0] raster_size;
        logic [31:0] dpm;
    } t_hdr_info;

    function automatic logic [7:0] hdr_byte(logic [HDR_POS_W-1:0] pos, t_hdr_info hi);
        logic [HDR_POS_W-1:0] off;
        logic [3:0]           word_idx;
        logic [31:0]          word;
        logic [7:0]           b;
        off      = pos - HDR_POS_W'(2);
        word_idx = off[5:2];
        unique case (word_idx)
            4'd0:    word = hi.file_size;
            4'd2:    word = 32'(HDR_BYTES);
            4'd3:    word = 32'(INFO_SIZE);
            4'd4:    word = {16'd0, hi.width};
            4'd5:    word = {16'd0, hi.height};
            4'd6:    word = 32'h0001_0001;   // planes, bits per pixel
            4'd8:    word = hi.raster_size;
            4'd9:    word = hi.dpm;
            4'd10:   word = hi.dpm;
            4'd11:   word = 32'd2;           // palette entries
            4'd14:   word = WHITE_RGB;
            default: word = '0;
        endcase
        case (off[1:0])
            2'd0:    b = word[7:0];
            2'd1:    b = word[15:8];
            2'd2:    b = word[23:16];
            default: b = word[31:24];
        endcase
        if (pos == HDR_POS_W'(0)) begin
            b = 8'h42;
        end else if (pos == HDR_POS_W'(1)) begin
            b = 8'h4D;
        end
        return b;
    endfunction

endpackage

[design/mbw_front.sv]
// ---------------------------------------------------------------------------
// mbw_front
// Holds the registers, tracks the byte position within a row and turns each
// item into a job for the back end; also derives the header fields.
// ---------------------------------------------------------------------------
module mbw_front #(
    parameter int unsigned MAX_WIDTH = mbw_pkg::MAX_WIDTH_DEF
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_cfg_we,
    input  logic [mbw_pkg::CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [mbw_pkg::CFG_DATA_W-1:0] i_cfg_data,
    input  logic                           i_valid,
    input  logic                           i_command,
    input  logic [7:0]                     i_pixel_byte,
    input  logic                           i_full,
    output logic                           o_push,
    output mbw_pkg::t_desc                 o_desc,
    output mbw_pkg::t_hdr_info             o_hdr
);
    import mbw_pkg::*;

    localparam int unsigned MAX_BPR = (MAX_WIDTH + 7) / 8;
    localparam int unsigned BIR_W   = (MAX_BPR > 1) ? $clog2(MAX_BPR) : 1;

    logic [15:0]      r_width, r_height, r_dpi;
    logic [BIR_W-1:0] r_bir, n_bir;

    logic [15:0] eff_w;
    logic [13:0] bpr, row_bytes, cnt_ext;
    logic [1:0]  pad;
    logic        row_end, accept;
    logic [7:0]  inv, last_mask;

    logic [31:0]       r_raster_size, r_file_size;
    logic [DPM_W-1:0]  r_dpm_base, r_dpm_base2, r_dpm_base3, r_dpm_x, r_dpm_x2, r_dpm;
    logic [PROD_W-1:0] r_dpm_prod;
    logic [15:0]       r_dpm_q, q0, q;
    logic [DPM_W-1:0]  rem;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_width  <= RST_WIDTH;
            r_height <= RST_HEIGHT;
            r_dpi    <= RST_DPI;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                CFG_IMAGE_WIDTH:    r_width  <= i_cfg_data;
                CFG_IMAGE_HEIGHT:   r_height <= i_cfg_data;
                CFG_RESOLUTION_DPI: r_dpi    <= i_cfg_data;
                default: ;
            endcase
        end
    end

    assign eff_w     = (r_width > 16'(MAX_WIDTH)) ? 16'(MAX_WIDTH) : r_width;
    assign bpr       = 14'(({1'b0, eff_w} + 17'd7) >> 3);
    assign row_bytes = (bpr + 14'd3) & ~14'd3;
    assign pad       = 2'd0 - bpr[1:0];
    assign cnt_ext   = 14'(r_bir);
    assign row_end   = (cnt_ext + 14'd1) >= bpr;
    assign inv       = ~i_pixel_byte;
    // clear the unused low bits of the last byte of a row
    assign last_mask = (eff_w[2:0] == 3'd0) ? 8'hFF : ~(8'hFF >> eff_w[2:0]);

    assign accept = i_valid && !i_full;
    assign o_push = accept;

    always_comb begin
        o_desc.kind = DESC_DATA;
        o_desc.data = 8'h00;
        o_desc.pad  = 2'd0;
        n_bir       = r_bir;
        if (i_command == CMD_HEADER) begin
            o_desc.kind = DESC_HEADER;
            if (accept) begin
                n_bir = '0;
            end
        end else if (eff_w == 16'd0) begin
            if (accept) begin
                n_bir = '0;
            end
        end else if (row_end) begin
            o_desc.data = inv & last_mask;
            o_desc.pad  = pad;
            if (accept) begin
                n_bir = '0;
            end
        end else begin
            o_desc.data = inv;
            if (accept) begin
                n_bir = r_bir + BIR_W'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_bir <= '0;
        end else begin
            r_bir <= n_bir;
        end
    end

    // header fields follow the registers continuously
    always_ff @(posedge i_clk) begin
        r_raster_size <= 32'(row_bytes) * 32'(r_height);
        r_file_size   <= r_raster_size + 32'(HDR_BYTES);
        r_dpm_base    <= DPM_W'({6'd0, r_dpi} * DPM_W'(DPM_WHOLE));
        r_dpm_x       <= DPM_W'({6'd0, r_dpi} * DPM_W'(DPM_FRAC));
        r_dpm_prod    <= PROD_W'(r_dpm_x) * PROD_W'(RECIP);
        r_dpm_x2      <= r_dpm_x;
        r_dpm_base2   <= r_dpm_base;
        r_dpm_q       <= q;
        r_dpm_base3   <= r_dpm_base2;
        r_dpm         <= r_dpm_base3 + DPM_W'(r_dpm_q);
    end

    // reciprocal estimate is low by at most one
    assign q0  = 16'(r_dpm_prod >> RECIP_SHIFT);
    assign rem = r_dpm_x2 - DPM_W'(q0) * DPM_W'(DPM_DEN);
    assign q   = (rem >= DPM_W'(DPM_DEN)) ? q0 + 16'd1 : q0;

    assign o_hdr.width       = eff_w;
    assign o_hdr.height      = r_height;
    assign o_hdr.file_size   = r_file_size;
    assign o_hdr.raster_size = r_raster_size;
    assign o_hdr.dpm         = 32'(r_dpm);

    a_hdr_restarts_row: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept && i_command == CMD_HEADER |=> r_bir == '0)
        else $error("row position not cleared by header");
    a_bir_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        cnt_ext < 14'(MAX_BPR))
        else $error("row position beyond widest row");
    a_pad_only_at_row_end: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_push && o_desc.pad != 2'd0 |-> o_desc.kind == DESC_DATA && row_end)
        else $error("padding requested away from row end");

endmodule

[design/mbw_fifo.sv]
// ---------------------------------------------------------------------------
// mbw_fifo
// Short job queue between the front end and the back end.
// ---------------------------------------------------------------------------
module mbw_fifo #(
    parameter int unsigned DEPTH = mbw_pkg::QUEUE_DEPTH_DEF
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_push,
    input  mbw_pkg::t_desc i_desc,
    input  logic           i_pop,
    output mbw_pkg::t_desc o_head,
    output logic           o_full,
    output logic           o_empty
);
    import mbw_pkg::*;

    localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int unsigned CNT_W = $clog2(DEPTH + 1);

    t_desc            r_mem [DEPTH];
    logic [PTR_W-1:0] r_wr, r_rd;
    logic [CNT_W-1:0] r_count;

    assign o_full  = r_count == CNT_W'(DEPTH);
    assign o_empty = r_count == '0;
    assign o_head  = r_mem[r_rd];

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr] <= i_desc;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= '0;
            r_rd    <= '0;
            r_count <= '0;
        end else begin
            if (i_push) begin
                r_wr <= (r_wr == PTR_W'(DEPTH - 1)) ? '0 : r_wr + PTR_W'(1);
            end
            if (i_pop) begin
                r_rd <= (r_rd == PTR_W'(DEPTH - 1)) ? '0 : r_rd + PTR_W'(1);
            end
            if (i_push && !i_pop) begin
                r_count <= r_count + CNT_W'(1);
            end else if (i_pop && !i_push) begin
                r_count <= r_count - CNT_W'(1);
            end
        end
    end

    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_push |-> !o_full)
        else $error("push into full queue");
    a_no_underflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_pop |-> !o_empty)
        else $error("pop from empty queue");
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CNT_W'(DEPTH))
        else $error("queue count out of range");

endmodule

[design/mbw_back.sv]
// ---------------------------------------------------------------------------
// mbw_back
// Expands queued jobs into output bytes: the header, a data byte and the
// row padding, one byte per cycle into the output register unless it stalls.
// ---------------------------------------------------------------------------
module mbw_back (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  mbw_pkg::t_desc     i_head,
    input  logic               i_empty,
    input  mbw_pkg::t_hdr_info i_hdr,
    output logic               o_pop,
    output logic               o_valid,
    output logic [7:0]         o_byte,
    output logic               o_last,
    input  logic               i_stall
);
    import mbw_pkg::*;

    logic [HDR_POS_W-1:0] r_pos, n_pos;
    logic                 r_valid, r_last;
    logic [7:0]           r_byte, n_byte;
    logic                 slot_free, go, run_last;

    assign slot_free = !r_valid || !i_stall;
    assign go        = slot_free && !i_empty;

    always_comb begin
        unique case (i_head.kind)
            DESC_HEADER: begin
                run_last = r_pos == HDR_POS_W'(HDR_BYTES - 1);
                n_byte   = hdr_byte(r_pos, i_hdr);
            end
            default: begin
                run_last = r_pos == HDR_POS_W'(i_head.pad);
                n_byte   = (r_pos == '0) ? i_head.data : 8'h00;
            end
        endcase
    end

    assign o_pop = go && run_last;

    always_comb begin
        n_pos = r_pos;
        if (go) begin
            n_pos = run_last ? '0 : r_pos + HDR_POS_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos   <= '0;
            r_valid <= 1'b0;
        end else begin
            r_pos <= n_pos;
            if (go) begin
                r_valid <= 1'b1;
            end else if (!i_stall) begin
                r_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (go) begin
            r_byte <= n_byte;
            r_last <= run_last;
        end
    end

    assign o_valid = r_valid;
    assign o_byte  = r_byte;
    assign o_last  = r_last;

    a_run_keeps_job: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_pos != '0 |-> !i_empty)
        else $error("job left the queue mid-run");
    a_pos_in_header: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_pos < HDR_POS_W'(HDR_BYTES))
        else $error("header position out of range");
    a_pos_in_pad: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !i_empty && i_head.kind == DESC_DATA |-> r_pos <= HDR_POS_W'(i_head.pad))
        else $error("padding run overshoots");

endmodule

[design/mono_bmp_stream_writer.sv]
// ---------------------------------------------------------------------------
// mono_bmp_stream_writer
// Streams a 1-bit-per-pixel BMP file: header on command, then inverted row
// bytes with end-of-row masking and padding to four bytes.
// ---------------------------------------------------------------------------
// Input items are taken one per cycle while the job queue (QUEUE_DEPTH
// entries) has room; the output side delivers one byte per cycle while
// the output is not stalled. A pixel byte inside a row gives one byte, the
// last byte of a row gives one to four (data plus zero padding to the next
// four-byte boundary), and a header command gives 62 bytes, all issued by
// the back end at one byte per cycle when not stalled, so pixel bytes inside
// a row sustain one item per cycle, while each row end and header holds the
// back end for all of its bytes and the queue absorbs items until it fills.
// Each item passes through the job queue and the back end's output register
// before its first byte appears. The header's size and resolution fields
// are derived from the registers through a short registered pipeline.
// ---------------------------------------------------------------------------
module mono_bmp_stream_writer #(
    parameter int unsigned MAX_WIDTH   = mbw_pkg::MAX_WIDTH_DEF,
    parameter int unsigned QUEUE_DEPTH = mbw_pkg::QUEUE_DEPTH_DEF
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_cfg_we,
    input  logic [mbw_pkg::CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [mbw_pkg::CFG_DATA_W-1:0] i_cfg_data,
    input  logic                           i_in_valid,
    output logic                           o_in_stall,
    input  logic                           i_command,
    input  logic [7:0]                     i_pixel_byte,
    output logic                           o_out_valid,
    input  logic                           i_out_stall,
    output logic [7:0]                     o_out_byte,
    output logic                           o_last_of_run
);
    import mbw_pkg::*;

    logic      push, pop, full, empty;
    t_desc     desc, head;
    t_hdr_info hdr;

    assign o_in_stall = full;

    mbw_front #(
        .MAX_WIDTH(MAX_WIDTH)
    ) u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_idx   (i_cfg_idx),
        .i_cfg_data  (i_cfg_data),
        .i_valid     (i_in_valid),
        .i_command   (i_command),
        .i_pixel_byte(i_pixel_byte),
        .i_full      (full),
        .o_push      (push),
        .o_desc      (desc),
        .o_hdr       (hdr)
    );

    mbw_fifo #(
        .DEPTH(QUEUE_DEPTH)
    ) u_fifo (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_push (push),
        .i_desc (desc),
        .i_pop  (pop),
        .o_head (head),
        .o_full (full),
        .o_empty(empty)
    );

    mbw_back u_back (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_head (head),
        .i_empty(empty),
        .i_hdr  (hdr),
        .o_pop  (pop),
        .o_valid(o_out_valid),
        .o_byte (o_out_byte),
        .o_last (o_last_of_run),
        .i_stall(i_out_stall)
    );

endmodule
